FILE: hdl/stru_pkg.sv
// ----------------------------------------------------------------------------
// stru_pkg: shared types and constants of the sparing table remap unit
// Item structs, operation and status codes, and the token that walks the
// row of table cells.
// ----------------------------------------------------------------------------
package stru_pkg;

  localparam int TableEntries = 64;
  localparam int PosW = $clog2(TableEntries + 1);
  localparam int IdxW = 6;

  localparam logic [31:0] LocAvailable = 32'hFFFF_FFF0;
  localparam logic [31:0] LocCorrupted = 32'hFFFF_FFF1;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_READ   = 3'd1,
    OP_XLATE  = 3'd2,
    OP_REMAP  = 3'd3,
    OP_UNMAP  = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_RSVD6  = 3'd6,
    OP_RSVD7  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMAPPED = 2'd2,
    ST_NO_TABLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_PKT_LOG2 = 2'd1,
    REG_IN_USE   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_APPLY,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] block_addr;
    logic [31:0] block_count;
    logic        allow_respare;
    logic [5:0]  entry_index;
    logic [31:0] entry_original;
    logic [31:0] entry_spare;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] location;
    logic [31:0] read_original;
    logic [31:0] read_spare;
    logic [6:0]  free_spares;
    logic        table_changed;
  } rsp_t;

  // token handed from cell to cell; pass 0 gathers, pass 1 applies
  typedef struct packed {
    op_t              op;
    logic             apply;
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  used;
    logic [31:0]      addr;
    logic [31:0]      mask;
    logic [16:0]      bs;
    logic [32:0]      range_end;
    logic [IdxW-1:0]  idx;
    logic [31:0]      eo;
    logic [31:0]      es;
    logic             act;
    logic             found;
    logic [PosW-1:0]  hit_pos;
    logic             claimed;
    logic [31:0]      loc;
    logic [31:0]      rd_o;
    logic [31:0]      rd_s;
    logic [PosW-1:0]  free;
    logic             chg;
  } tok_t;

endpackage

FILE: hdl/stru_cell.sv
// ----------------------------------------------------------------------------
// stru_cell: one sparing table entry
// Holds an original/spare pair, acts on the passing token and hands the
// updated token to the next cell through a register.
// ----------------------------------------------------------------------------
module stru_cell (
  input  logic          clk,
  input  logic          rst,
  input  stru_pkg::tok_t tok_in,
  input  logic          tok_in_valid,
  output stru_pkg::tok_t tok_out,
  output logic          tok_out_valid
);
  import stru_pkg::*;

  logic [31:0] orig;
  logic [31:0] spare;
  logic [31:0] orig_next;
  logic [31:0] spare_next;
  tok_t        tok_next;
  logic        in_use;
  logic        marker;
  logic        here;

  // entry evaluation
  always_comb begin
    tok_next   = tok_in;
    orig_next  = orig;
    spare_next = spare;
    in_use     = tok_in.pos < tok_in.used;
    marker     = (orig == LocAvailable) || (orig == LocCorrupted);
    here       = tok_in.pos == {1'b0, tok_in.idx};
    if (!tok_in.apply) begin
      if (tok_in.op == OP_READ && here) begin
        tok_next.rd_o = orig;
        tok_next.rd_s = spare;
      end
      if (in_use && !marker && ((orig ^ tok_in.addr) & tok_in.mask) == 32'd0 &&
          !tok_in.found) begin
        tok_next.found   = 1'b1;
        tok_next.hit_pos = tok_in.pos;
        tok_next.loc     = spare + tok_in.addr - orig;
      end
    end else begin
      case (tok_in.op)
        OP_LOAD: begin
          if (here) begin
            orig_next  = tok_in.eo;
            spare_next = tok_in.es;
          end
        end
        OP_REMAP: begin
          if (tok_in.act) begin
            if (tok_in.found && tok_in.pos == tok_in.hit_pos) begin
              orig_next    = LocCorrupted;
              tok_next.chg = 1'b1;
            end else if (in_use && orig == LocAvailable && !tok_in.claimed) begin
              orig_next        = tok_in.addr & tok_in.mask;
              tok_next.loc     = spare;
              tok_next.claimed = 1'b1;
              tok_next.chg     = 1'b1;
            end
          end
        end
        OP_UNMAP: begin
          if (tok_in.act && in_use && !marker && orig >= tok_in.addr &&
              ({1'b0, orig} + {16'd0, tok_in.bs}) <= tok_in.range_end) begin
            orig_next    = LocAvailable;
            tok_next.chg = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // free count taken after any update of this entry
    if (in_use && (tok_in.apply ? orig_next : orig) == LocAvailable) begin
      tok_next.free = tok_in.free + 1'b1;
    end
    tok_next.pos = tok_in.pos + 1'b1;
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (tok_in_valid && tok_in.apply) begin
      orig  <= orig_next;
      spare <= spare_next;
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule

FILE: hdl/sparing_table_remap_unit.sv
// ----------------------------------------------------------------------------
// sparing_table_remap_unit: bad-packet sparing table with remap engine
// Row of 64 entry cells walked by an operation token, with APB registers.
// ----------------------------------------------------------------------------
// The token walks the 64-cell row twice, once to gather the match, free count
// and read data, once to apply the changes and count free entries afterward.
// The next item can be taken once the result is loaded into the output
// register. One item is in flight at a time; a finished result waits in the
// output register and a stalled result holds off the next item.
// Table entries are undefined until loaded and need no clearing after reset.
module sparing_table_remap_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  stru_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output stru_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import stru_pkg::*;

  state_t      state;
  state_t      state_next;
  logic        sparing_enabled;
  logic [4:0]  packet_size_log2;
  logic [6:0]  entries_in_use;
  logic        changed_flag;
  tok_t        inj;
  tok_t        inj_next;
  logic        inj_valid;
  logic        inj_respare;
  tok_t        done_tok;
  logic [1:0]  status;
  logic [1:0]  status_next;
  tok_t        chain_tok [TableEntries+1];
  logic        chain_vld [TableEntries+1];
  tok_t        exit_tok;
  logic        exit_valid;
  logic [4:0]  k;
  logic [31:0] mask;
  logic [PosW-1:0] used;
  logic        load_rsp;
  reg_idx_t    widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sparing_enabled  <= 1'b0;
      packet_size_log2 <= 5'd5;
      entries_in_use   <= 7'd0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_ENABLE:   sparing_enabled  <= pwdata[0];
        REG_PKT_LOG2: packet_size_log2 <= pwdata[4:0];
        REG_IN_USE:   entries_in_use   <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_ENABLE:   prdata = {31'd0, sparing_enabled};
      REG_PKT_LOG2: prdata = {27'd0, packet_size_log2};
      REG_IN_USE:   prdata = {25'd0, entries_in_use};
      default:      prdata = 32'd0;
    endcase
  end

  // derived packet and count values
  always_comb begin
    k    = (packet_size_log2 > 5'd16) ? 5'd16 : packet_size_log2;
    mask = ~((32'd1 << k) - 32'd1);
    used = (entries_in_use > 7'(TableEntries)) ? PosW'(TableEntries) :
           PosW'(entries_in_use);
  end

  // cell row
  assign chain_tok[0] = inj;
  assign chain_vld[0] = inj_valid;
  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    stru_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .tok_in       (chain_tok[g]),
      .tok_in_valid (chain_vld[g]),
      .tok_out      (chain_tok[g+1]),
      .tok_out_valid(chain_vld[g+1])
    );
  end
  assign exit_tok   = chain_tok[TableEntries];
  assign exit_valid = chain_vld[TableEntries];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    load_rsp   = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) state_next = S_GATHER;
      end
      S_GATHER: begin
        if (exit_valid) state_next = S_APPLY;
      end
      S_APPLY: begin
        if (exit_valid) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // token injection and result capture
  always_ff @(posedge clk) begin
    if (rst) begin
      inj_valid    <= 1'b0;
      rsp_valid    <= 1'b0;
      changed_flag <= 1'b0;
    end else begin
      inj_valid <= (state == S_IDLE && req_valid) || (state == S_GATHER && exit_valid);
      if (load_rsp) begin
        rsp_valid <= 1'b1;
        if (done_tok.op == OP_CLEAR) begin
          changed_flag <= 1'b0;
        end else if (done_tok.chg) begin
          changed_flag <= 1'b1;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // next token and status: new item, the gathered token turned to apply, or a full status after apply
  always_comb begin
    inj_next    = inj;
    status_next = status;
    if (state == S_IDLE && req_valid) begin
      inj_next.op        = op_t'(req.op);
      inj_next.apply     = 1'b0;
      inj_next.pos       = '0;
      inj_next.used      = used;
      inj_next.addr      = req.block_addr;
      inj_next.mask      = mask;
      inj_next.bs        = 17'd1 << k;
      inj_next.range_end = {1'b0, req.block_addr} + {1'b0, req.block_count};
      inj_next.idx       = req.entry_index;
      inj_next.eo        = req.entry_original;
      inj_next.es        = req.entry_spare;
      inj_next.act       = 1'b0;
      inj_next.found     = 1'b0;
      inj_next.hit_pos   = '0;
      inj_next.claimed   = 1'b0;
      inj_next.loc       = 32'd0;
      inj_next.rd_o      = 32'd0;
      inj_next.rd_s      = 32'd0;
      inj_next.free      = '0;
      inj_next.chg       = 1'b0;
    end else if (state == S_GATHER && exit_valid) begin
      inj_next         = exit_tok;
      inj_next.apply   = 1'b1;
      inj_next.pos     = '0;
      inj_next.free    = '0;
      inj_next.chg     = 1'b0;
      inj_next.claimed = 1'b0;
      inj_next.act     = 1'b0;
      inj_next.loc     = 32'd0;
      status_next      = ST_OK;
      case (exit_tok.op)
        OP_XLATE: begin
          inj_next.loc = (sparing_enabled && exit_tok.found) ? exit_tok.loc : exit_tok.addr;
        end
        OP_REMAP: begin
          if (!sparing_enabled) begin
            status_next = ST_NO_TABLE;
          end else if (exit_tok.free == '0) begin
            status_next = ST_FULL;
          end else if (exit_tok.found && !inj_respare) begin
            status_next = ST_REMAPPED;
          end else begin
            inj_next.act = 1'b1;
          end
        end
        OP_UNMAP: inj_next.act = sparing_enabled;
        default: begin
        end
      endcase
    end else if (state == S_APPLY && exit_valid) begin
      if (exit_tok.op == OP_REMAP && exit_tok.act && !exit_tok.claimed) begin
        status_next = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    inj    <= inj_next;
    status <= status_next;
    if (state == S_APPLY && exit_valid) begin
      done_tok <= exit_tok;
    end
    if (load_rsp) begin
      rsp.status        <= status;
      rsp.location      <= done_tok.loc;
      rsp.read_original <= done_tok.rd_o;
      rsp.read_spare    <= done_tok.rd_s;
      rsp.free_spares   <= 7'(done_tok.free);
      rsp.table_changed <= (done_tok.op == OP_CLEAR) ? 1'b0 :
                           (changed_flag | done_tok.chg);
    end
  end

  // respare request kept for the decision between passes
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      inj_respare <= req.allow_respare;
    end
  end

endmodule

FILE: tb/sparing_table_remap_unit_tb.sv
// ----------------------------------------------------------------------------
// sparing_table_remap_unit_tb: self-checking bench for the sparing table
// Drives load, read, translate, remap, unmap and clear items with random
// gaps and stalls, predicts each result from a local copy of the table and
// registers, and compares every field in order of arrival.
// ----------------------------------------------------------------------------
module sparing_table_remap_unit_tb;
  import stru_pkg::*;

  localparam int ItemCycles = 140;
  localparam int WatchLimit = 4000;
  localparam int HoldCycles = 600;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // local copy of the table and registers
  logic [31:0] orig_tbl [TableEntries];
  logic [31:0] spare_tbl [TableEntries];
  logic        changed;
  logic        enable_reg;
  logic [4:0]  pkt_log2_reg;
  logic [6:0]  in_use_reg;

  rsp_t        expected_rsps [$];
  int          error_count;
  int          rsp_count;
  int          idle_pct;
  int          stall_pct;
  bit          hold_off;
  int          quiet_cycles;
  int          op_seen [8];

  sparing_table_remap_unit u_top (
    .clk, .rst, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // searched entry count and packet size after clamping
  function automatic int searched();
    return (in_use_reg > TableEntries) ? TableEntries : int'(in_use_reg);
  endfunction

  function automatic logic [31:0] packet_mask();
    int k;
    k = (pkt_log2_reg > 16) ? 16 : int'(pkt_log2_reg);
    return ~((32'd1 << k) - 32'd1);
  endfunction

  function automatic bit is_mark(logic [31:0] w);
    return (w == LocAvailable) || (w == LocCorrupted);
  endfunction

  function automatic int free_entries();
    int c;
    c = 0;
    for (int i = 0; i < searched(); i++) if (orig_tbl[i] == LocAvailable) c++;
    return c;
  endfunction

  function automatic int packet_hit(logic [31:0] a);
    logic [31:0] m;
    m = packet_mask();
    for (int i = 0; i < searched(); i++)
      if (!is_mark(orig_tbl[i]) && ((orig_tbl[i] & m) == (a & m))) return i;
    return -1;
  endfunction

  // work out the result of one item and update the local table
  function automatic rsp_t predict_table_op(req_t r);
    rsp_t        o;
    int          h;
    logic [31:0] a;
    logic [32:0] lim;
    logic [32:0] bs;
    o = '0;
    case (op_t'(r.op))
      OP_LOAD: begin
        orig_tbl[r.entry_index] = r.entry_original;
        spare_tbl[r.entry_index] = r.entry_spare;
      end
      OP_READ: begin
        o.read_original = orig_tbl[r.entry_index];
        o.read_spare = spare_tbl[r.entry_index];
      end
      OP_XLATE: begin
        o.location = r.block_addr;
        if (enable_reg) begin
          h = packet_hit(r.block_addr);
          if (h >= 0) o.location = spare_tbl[h] + r.block_addr - orig_tbl[h];
        end
      end
      OP_REMAP: begin
        if (!enable_reg) o.status = ST_NO_TABLE;
        else if (free_entries() == 0) o.status = ST_FULL;
        else begin
          a = r.block_addr & packet_mask();
          h = packet_hit(a);
          if (h >= 0 && !r.allow_respare) o.status = ST_REMAPPED;
          else begin
            if (h >= 0) begin
              orig_tbl[h] = LocCorrupted;
              changed = 1'b1;
            end
            o.status = ST_FULL;
            for (int i = 0; i < searched(); i++) begin
              if (orig_tbl[i] == LocAvailable) begin
                orig_tbl[i] = a;
                changed = 1'b1;
                o.location = spare_tbl[i];
                o.status = ST_OK;
                break;
              end
            end
          end
        end
      end
      OP_UNMAP: begin
        if (enable_reg) begin
          lim = {1'b0, r.block_addr} + {1'b0, r.block_count};
          bs = {1'b0, ~packet_mask()} + 33'd1;
          for (int i = 0; i < searched(); i++) begin
            if (!is_mark(orig_tbl[i]) && orig_tbl[i] >= r.block_addr &&
                ({1'b0, orig_tbl[i]} + bs) <= lim) begin
              orig_tbl[i] = LocAvailable;
              changed = 1'b1;
            end
          end
        end
      end
      OP_CLEAR: changed = 1'b0;
      default: ;
    endcase
    o.free_spares = 7'(free_entries());
    o.table_changed = changed;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // send one item; prediction happens at acceptance
  task automatic send_item(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    expected_rsps.push_back(predict_table_op(r));
    op_seen[r.op]++;
  endtask

  task automatic write_reg(reg_idx_t ri, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(ri) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (ri)
      REG_ENABLE: enable_reg = v[0];
      REG_PKT_LOG2: pkt_log2_reg = v[4:0];
      default: in_use_reg = v[6:0];
    endcase
  endtask

  // idle point: every result in, then the block's own latency
  task automatic drain();
    int n;
    n = 0;
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0 && n < 200 * ItemCycles) begin
      @(posedge clk);
      n++;
    end
    repeat (ItemCycles) @(posedge clk);
  endtask

  task automatic set_regs(logic en, logic [4:0] pl, logic [6:0] nu);
    drain();
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_PKT_LOG2, {27'd0, pl});
    write_reg(REG_IN_USE, {25'd0, nu});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic req_t blank_item(op_t o);
    req_t r;
    r = '0;
    r.op = o;
    return r;
  endfunction

  task automatic load_entry(int i, logic [31:0] o, logic [31:0] s);
    req_t r;
    r = blank_item(OP_LOAD);
    r.entry_index = 6'(i);
    r.entry_original = o;
    r.entry_spare = s;
    send_item(r);
  endtask

  // build a table: remaps and corrupted marks among the first n entries, rest available spares
  task automatic fill_table(int n, int used_rate);
    logic [31:0] w;
    for (int i = 0; i < TableEntries; i++) begin
      if (i < n && $urandom_range(99) < used_rate)
        w = (i % 7 == 0) ? LocCorrupted : ($urandom_range(3) == 0 ? $urandom() :
            32'($urandom_range(4095)) << pkt_log2_reg);
      else w = LocAvailable;
      load_entry(i, w, $urandom());
    end
  endtask

  function automatic req_t random_item(int n);
    req_t r;
    int   p;
    r = '0;
    r.op = 3'($urandom_range(7));
    if (r.op == OP_LOAD) r.op = OP_XLATE;
    p = $urandom_range(99);
    r.block_addr = (p < 60) ? 32'($urandom_range(4095)) << pkt_log2_reg |
                   32'($urandom_range(3)) : $urandom();
    r.block_count = (p < 50) ? 32'($urandom_range(8)) << pkt_log2_reg :
                    ($urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(300)));
    r.allow_respare = $urandom_range(1);
    r.entry_index = 6'($urandom_range(TableEntries - 1));
    r.entry_original = $urandom();
    r.entry_spare = $urandom();
    if ($urandom_range(9) == 0) begin
      r.op = OP_LOAD;
      r.entry_original = ($urandom_range(1) == 0) ? LocAvailable : r.entry_original;
    end
    if (r.op == OP_REMAP && $urandom_range(1) == 0) begin
      p = $urandom_range(n > 0 ? n - 1 : 0);
      if (!is_mark(orig_tbl[p])) r.block_addr = orig_tbl[p] + 32'($urandom_range(3));
    end
    return r;
  endfunction

  // directed: extremes, each op, disabled table, full table, respare
  task automatic test_directed();
    req_t r;
    set_regs(1'b0, 5'd5, 7'd0);
    fill_table(TableEntries, 0);
    load_entry(0, 32'h0000_0040, 32'h0010_0000);
    load_entry(1, 32'hFFFF_FFE0, 32'hFFFF_FFFF);
    r = blank_item(OP_REMAP);
    send_item(r);
    r = blank_item(OP_XLATE);
    r.block_addr = 32'h45;
    send_item(r);
    set_regs(1'b1, 5'd31, 7'd127);
    send_item(r);
    r = blank_item(OP_READ);
    r.entry_index = 6'd63;
    send_item(r);
    r = blank_item(OP_RSVD6);
    send_item(r);
    r = blank_item(OP_RSVD7);
    r.block_addr = '1;
    send_item(r);
    set_regs(1'b1, 5'd5, 7'd3);
    r = blank_item(OP_XLATE);
    r.block_addr = 32'h45;
    send_item(r);
    r.block_addr = 32'hFFFF_FFFF;
    send_item(r);
    r = blank_item(OP_REMAP);
    r.block_addr = 32'h4F;
    send_item(r);
    r.allow_respare = 1'b1;
    send_item(r);
    send_item(r);
    r = blank_item(OP_UNMAP);
    r.block_addr = 32'hFFFF_FFE0;
    r.block_count = 32'hFFFF_FFFF;
    send_item(r);
    r.block_addr = 32'd0;
    send_item(r);
    send_item(blank_item(OP_CLEAR));
    r = blank_item(OP_READ);
    r.entry_index = 6'd2;
    send_item(r);
    set_regs(1'b1, 5'd0, 7'd0);
    r = blank_item(OP_REMAP);
    send_item(r);
  endtask

  // random phases over several register settings
  task automatic test_random(int items);
    int pl;
    int nu;
    for (int ph = 0; ph < 8; ph++) begin
      pl = (ph == 0) ? 0 : (ph == 1) ? 16 : (ph == 2) ? 31 : $urandom_range(12);
      nu = (ph == 3) ? 64 : (ph == 4) ? 100 : (ph == 5) ? 1 : $urandom_range(2, 64);
      set_regs(ph != 6, 5'(pl), 7'(nu));
      idle_pct = (ph == 2) ? 0 : 30;
      stall_pct = (ph == 2) ? 0 : 30;
      fill_table(nu > 64 ? 64 : nu, 40);
      for (int k = 0; k < items / 8; k++) send_item(random_item(nu > 64 ? 64 : nu));
    end
    idle_pct = 30;
    stall_pct = 30;
  endtask

  // receiver holds off for a counted stretch while items keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int k = 0; k < 6; k++) send_item(random_item(searched()));
    join
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // checker
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_count++;
      if (expected_rsps.size() == 0) begin
        report_mismatch("result with nothing expected", 32'd0, 32'd0);
      end else begin
        e = expected_rsps.pop_front();
        if (rsp.status !== e.status) report_mismatch("status", 32'(rsp.status), 32'(e.status));
        if (rsp.location !== e.location) report_mismatch("location", rsp.location, e.location);
        if (rsp.read_original !== e.read_original)
          report_mismatch("read_original", rsp.read_original, e.read_original);
        if (rsp.read_spare !== e.read_spare)
          report_mismatch("read_spare", rsp.read_spare, e.read_spare);
        if (rsp.free_spares !== e.free_spares)
          report_mismatch("free_spares", 32'(rsp.free_spares), 32'(e.free_spares));
        if (rsp.table_changed !== e.table_changed)
          report_mismatch("table_changed", 32'(rsp.table_changed), 32'(e.table_changed));
      end
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_off = 1'b0;
    quiet_cycles = 0;
    error_count = 0;
    rsp_count = 0;
    idle_pct = 30;
    stall_pct = 30;
    changed = 1'b0;
    enable_reg = 1'b0;
    pkt_log2_reg = 5'd5;
    in_use_reg = 7'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(952);
    test_backpressure();
    drain();
    $display("Covered %0d results; ops load/read/xlate/remap/unmap/clear: %0d %0d %0d %0d %0d %0d",
             rsp_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5]);
    if (error_count == 0 && expected_rsps.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/stru_pkg.sv
hdl/stru_cell.sv
hdl/sparing_table_remap_unit.sv
tb/sparing_table_remap_unit_tb.sv
